### rtl/arp_pkg.sv
// Shared constants, status codes and the packet record type of the ARP parser.
package arp_pkg;

  // Longest packet that is counted; later bytes are neither counted nor captured.
  localparam int MAX_PACKET_BYTES = 2048;
  localparam int COUNT_LIMIT = (MAX_PACKET_BYTES < 4095) ? MAX_PACKET_BYTES : 4095;
  localparam int CNT_W = 12;

  // Depth of the record queue between the capture side and the result side.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // Field widths.
  localparam int MAC_W = 48;
  localparam int IP_W = 128;
  localparam int HDR_W = 64;

  // Protocol and header constants.
  localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] PTYPE_IPV6 = 16'h86DD;
  localparam logic [7:0] HLEN_ETHERNET = 8'd6;
  localparam logic [7:0] PLEN_IPV4 = 8'd4;
  localparam logic [7:0] PLEN_IPV6 = 8'd16;
  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY = 16'd2;

  // Byte offsets within the packet.
  localparam logic [CNT_W-1:0] OFS_SHA = CNT_W'(8);
  localparam logic [CNT_W-1:0] OFS_SPA = CNT_W'(14);
  localparam logic [CNT_W-1:0] OFS_THA_V4 = CNT_W'(18);
  localparam logic [CNT_W-1:0] OFS_TPA_V4 = CNT_W'(24);
  localparam logic [CNT_W-1:0] OFS_END_V4 = CNT_W'(28);
  localparam logic [CNT_W-1:0] OFS_THA_V6 = CNT_W'(30);
  localparam logic [CNT_W-1:0] OFS_TPA_V6 = CNT_W'(36);
  localparam logic [CNT_W-1:0] OFS_END_V6 = CNT_W'(52);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(COUNT_LIMIT);

  // Result status codes.
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_SHORT_HEADER = 3'd1;
  localparam logic [2:0] ST_BAD_HTYPE = 3'd2;
  localparam logic [2:0] ST_BAD_PTYPE = 3'd3;
  localparam logic [2:0] ST_BAD_HLEN = 3'd4;
  localparam logic [2:0] ST_BAD_PLEN = 3'd5;
  localparam logic [2:0] ST_BAD_OPCODE = 3'd6;
  localparam logic [2:0] ST_SHORT_PAYLOAD = 3'd7;

  // One captured packet, handed from the capture side to the result side.
  typedef struct packed {
    logic [HDR_W-1:0] header;
    logic             len_ge_hdr;
    logic             len_ge_v4;
    logic             len_ge_v6;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  sender_ip;
    logic [MAC_W-1:0] target_mac;
    logic [IP_W-1:0]  target_ip;
  } rec_t;

endpackage

### rtl/arp_front.sv
// Capture side: counts packet bytes and shifts header and address bytes into place.
module arp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  output logic          push_o,
  output arp_pkg::rec_t rec_o
);

  logic [arp_pkg::CNT_W-1:0] count_q, count_d;
  logic [arp_pkg::HDR_W-1:0] hdr_q, hdr_d;
  logic [arp_pkg::MAC_W-1:0] sha_q, sha_d, tha_q, tha_d;
  logic [arp_pkg::IP_W-1:0]  spa_q, spa_d, tpa_q, tpa_d;
  logic                      v6;
  logic [arp_pkg::CNT_W-1:0] ofs_tha, ofs_tpa, ofs_end;

  // Address layout follows the protocol type already held in the header.
  assign v6      = (hdr_q[47:32] == arp_pkg::PTYPE_IPV6);
  assign ofs_tha = v6 ? arp_pkg::OFS_THA_V6 : arp_pkg::OFS_THA_V4;
  assign ofs_tpa = v6 ? arp_pkg::OFS_TPA_V6 : arp_pkg::OFS_TPA_V4;
  assign ofs_end = v6 ? arp_pkg::OFS_END_V6 : arp_pkg::OFS_END_V4;

  // Route the current byte into the field that its position selects.
  always_comb begin
    count_d = count_q;
    hdr_d   = hdr_q;
    sha_d   = sha_q;
    spa_d   = spa_q;
    tha_d   = tha_q;
    tpa_d   = tpa_q;
    if (count_q < arp_pkg::CNT_MAX) begin
      count_d = count_q + 1'b1;
      if (count_q < arp_pkg::OFS_SHA) begin
        hdr_d = {hdr_q[arp_pkg::HDR_W-9:0], data_byte_i};
      end else if (count_q < arp_pkg::OFS_SPA) begin
        sha_d = {sha_q[arp_pkg::MAC_W-9:0], data_byte_i};
      end else if (count_q < ofs_tha) begin
        spa_d = {spa_q[arp_pkg::IP_W-9:0], data_byte_i};
      end else if (count_q < ofs_tpa) begin
        tha_d = {tha_q[arp_pkg::MAC_W-9:0], data_byte_i};
      end else if (count_q < ofs_end) begin
        tpa_d = {tpa_q[arp_pkg::IP_W-9:0], data_byte_i};
      end
    end
  end

  // The record carries the fields as they stand after the final byte.
  assign push_o            = accept_i && last_byte_i;
  assign rec_o.header      = hdr_d;
  assign rec_o.len_ge_hdr  = (count_d >= arp_pkg::OFS_SHA);
  assign rec_o.len_ge_v4   = (count_d >= arp_pkg::OFS_END_V4);
  assign rec_o.len_ge_v6   = (count_d >= arp_pkg::OFS_END_V6);
  assign rec_o.sender_mac  = sha_d;
  assign rec_o.sender_ip   = spa_d;
  assign rec_o.target_mac  = tha_d;
  assign rec_o.target_ip   = tpa_d;

  // Capture registers; they clear after the final byte of each packet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hdr_q   <= '0;
      sha_q   <= '0;
      spa_q   <= '0;
      tha_q   <= '0;
      tpa_q   <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        count_q <= '0;
        hdr_q   <= '0;
        sha_q   <= '0;
        spa_q   <= '0;
        tha_q   <= '0;
        tpa_q   <= '0;
      end else begin
        count_q <= count_d;
        hdr_q   <= hdr_d;
        sha_q   <= sha_d;
        spa_q   <= spa_d;
        tha_q   <= tha_d;
        tpa_q   <= tpa_d;
      end
    end
  end

endmodule

### rtl/arp_fifo.sv
// Short record queue between the capture side and the result side.
module arp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  arp_pkg::rec_t rec_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output arp_pkg::rec_t rec_o
);

  arp_pkg::rec_t              mem_q [arp_pkg::QDEPTH];
  logic [arp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [arp_pkg::QPTR_W:0]   fill_q;
  logic                       do_push, do_pop;

  assign full_o  = (fill_q == (arp_pkg::QPTR_W + 1)'(arp_pkg::QDEPTH));
  assign valid_o = (fill_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage needs no reset; the fill count guards every read.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == arp_pkg::QPTR_W'(arp_pkg::QDEPTH - 1)) ? '0
                                                                         : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == arp_pkg::QPTR_W'(arp_pkg::QDEPTH - 1)) ? '0
                                                                         : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

### rtl/arp_back.sv
// Result side: checks the captured header and registers one result per packet.
module arp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rec_valid_i,
  input  arp_pkg::rec_t             rec_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                status_o,
  output logic                      is_reply_o,
  output logic                      is_ipv6_o,
  output logic [arp_pkg::MAC_W-1:0] sender_mac_o,
  output logic [63:0]               sender_ip_upper_o,
  output logic [63:0]               sender_ip_lower_o,
  output logic [arp_pkg::MAC_W-1:0] target_mac_o,
  output logic [63:0]               target_ip_upper_o,
  output logic [63:0]               target_ip_lower_o
);

  logic [15:0] htype, ptype, opcode;
  logic [7:0]  hlen, plen;
  logic        v6, ok;
  logic [2:0]  status_d;

  logic                      valid_q;
  logic [2:0]                status_q;
  logic                      reply_q, v6_q;
  logic [arp_pkg::MAC_W-1:0] smac_q, tmac_q;
  logic [arp_pkg::IP_W-1:0]  sip_q, tip_q;

  assign htype  = rec_i.header[63:48];
  assign ptype  = rec_i.header[47:32];
  assign hlen   = rec_i.header[31:24];
  assign plen   = rec_i.header[23:16];
  assign opcode = rec_i.header[15:0];
  assign v6     = (ptype == arp_pkg::PTYPE_IPV6);

  // The first check that fails sets the status.
  always_comb begin
    if (!rec_i.len_ge_hdr) begin
      status_d = arp_pkg::ST_SHORT_HEADER;
    end else if (htype != arp_pkg::HTYPE_ETHERNET) begin
      status_d = arp_pkg::ST_BAD_HTYPE;
    end else if (ptype != arp_pkg::PTYPE_IPV4 && ptype != arp_pkg::PTYPE_IPV6) begin
      status_d = arp_pkg::ST_BAD_PTYPE;
    end else if (hlen != arp_pkg::HLEN_ETHERNET) begin
      status_d = arp_pkg::ST_BAD_HLEN;
    end else if (plen != (v6 ? arp_pkg::PLEN_IPV6 : arp_pkg::PLEN_IPV4)) begin
      status_d = arp_pkg::ST_BAD_PLEN;
    end else if (opcode != arp_pkg::OP_REQUEST && opcode != arp_pkg::OP_REPLY) begin
      status_d = arp_pkg::ST_BAD_OPCODE;
    end else if (!(v6 ? rec_i.len_ge_v6 : rec_i.len_ge_v4)) begin
      status_d = arp_pkg::ST_SHORT_PAYLOAD;
    end else begin
      status_d = arp_pkg::ST_OK;
    end
  end

  assign ok    = (status_d == arp_pkg::ST_OK);
  assign pop_o = rec_valid_i && (!valid_q || out_ready_i);

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= rec_valid_i;
    end
  end

  // Output payload; every field but the status reads zero on an error.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
      reply_q  <= ok && (opcode == arp_pkg::OP_REPLY);
      v6_q     <= ok && v6;
      smac_q   <= ok ? rec_i.sender_mac : '0;
      sip_q    <= ok ? rec_i.sender_ip : '0;
      tmac_q   <= ok ? rec_i.target_mac : '0;
      tip_q    <= ok ? rec_i.target_ip : '0;
    end
  end

  assign out_valid_o       = valid_q;
  assign status_o          = status_q;
  assign is_reply_o        = reply_q;
  assign is_ipv6_o         = v6_q;
  assign sender_mac_o      = smac_q;
  assign sender_ip_upper_o = sip_q[127:64];
  assign sender_ip_lower_o = sip_q[63:0];
  assign target_mac_o      = tmac_q;
  assign target_ip_upper_o = tip_q[127:64];
  assign target_ip_lower_o = tip_q[63:0];

endmodule

### rtl/arp_packet_parser.sv
// Top level of the ARP packet parser: capture side, record queue and result side.
//
// The parser takes one ARP packet byte per clock while in_ready_o is high, starting at
// the ARP header, with last_byte_i marking the final byte, and gives one result per
// packet. The capture side shifts each byte into the header or address field that its
// position selects. On the final byte the captured fields enter a two-entry queue,
// and the result side checks them and loads the output register, which drives
// out_valid_o. in_ready_o drops only while the queue holds two records, which happens
// only when the output is stalled. Bytes past the 2048th of a packet are ignored.
module arp_packet_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        is_reply_o,
  output logic        is_ipv6_o,
  output logic [47:0] sender_mac_o,
  output logic [63:0] sender_ip_upper_o,
  output logic [63:0] sender_ip_lower_o,
  output logic [47:0] target_mac_o,
  output logic [63:0] target_ip_upper_o,
  output logic [63:0] target_ip_lower_o
);

  logic          accept, push, full, pop, head_valid;
  arp_pkg::rec_t push_rec, head_rec;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  // Byte capture.
  arp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  // Record queue.
  arp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rec_o   (head_rec)
  );

  // Checks and output register.
  arp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rec_valid_i       (head_valid),
    .rec_i             (head_rec),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .is_reply_o        (is_reply_o),
    .is_ipv6_o         (is_ipv6_o),
    .sender_mac_o      (sender_mac_o),
    .sender_ip_upper_o (sender_ip_upper_o),
    .sender_ip_lower_o (sender_ip_lower_o),
    .target_mac_o      (target_mac_o),
    .target_ip_upper_o (target_ip_upper_o),
    .target_ip_lower_o (target_ip_lower_o)
  );

endmodule
